// ===== src/ttc_collision_threat_classifier_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Collision threat classifier assertion macros
// Concurrent assertion helpers shared by the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef TTC_COLLISION_THREAT_CLASSIFIER_UNIT_MACROS_SVH
`define TTC_COLLISION_THREAT_CLASSIFIER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define TTC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttc assertion failed: same-cycle implication");

// next-cycle implication
`define TTC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttc assertion failed: next-cycle implication");

`else

`define TTC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TTC_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== src/ttc_pkg.sv =====
// ----------------------------------------------------------------------------
// Collision threat classifier package
// Payload, register and status types plus fixed codes and reset values.
// ----------------------------------------------------------------------------
package ttc_pkg;

   // register indexes
   localparam logic [2:0] CSR_TTC_CRITICAL_LIMIT   = 3'd0;
   localparam logic [2:0] CSR_TTC_WARNING_LIMIT    = 3'd1;
   localparam logic [2:0] CSR_EGO_LANE_HALF_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_WARN_ZONE_HALF_WIDTH = 3'd3;
   localparam logic [2:0] CSR_MAX_DISTANCE         = 3'd4;
   localparam logic [2:0] CSR_MIN_CLOSING_SPEED    = 3'd5;
   localparam logic [2:0] CSR_IMMINENT_DISTANCE    = 3'd6;

   // register reset values
   localparam logic [15:0] RST_TTC_CRITICAL_LIMIT   = 16'd384;
   localparam logic [15:0] RST_TTC_WARNING_LIMIT    = 16'd768;
   localparam logic [14:0] RST_EGO_LANE_HALF_WIDTH  = 15'd205;
   localparam logic [14:0] RST_WARN_ZONE_HALF_WIDTH = 15'd410;
   localparam logic [14:0] RST_MAX_DISTANCE         = 15'd7680;
   localparam logic [14:0] RST_MIN_CLOSING_SPEED    = 15'd512;
   localparam logic [14:0] RST_IMMINENT_DISTANCE    = 15'd1024;

   // threat levels
   localparam logic [1:0] LVL_SAFE     = 2'd0;
   localparam logic [1:0] LVL_WARNING  = 2'd1;
   localparam logic [1:0] LVL_CRITICAL = 2'd2;

   // reason codes
   localparam logic [2:0] RSN_SAFE         = 3'd0;
   localparam logic [2:0] RSN_FWD_CRITICAL = 3'd1;
   localparam logic [2:0] RSN_FWD_WARNING  = 3'd2;
   localparam logic [2:0] RSN_IMMINENT     = 3'd3;
   localparam logic [2:0] RSN_LANE_WARNING = 3'd4;

   localparam logic [15:0] TTC_MAX = 16'hFFFF;

   typedef struct packed {
      logic        [15:0] target_id;
      logic signed [15:0] lateral_position;
      logic signed [15:0] distance;
      logic signed [15:0] forward_velocity;
      logic               last;
   } ttc_req_type;

   typedef struct packed {
      logic [15:0] object_id;
      logic [1:0]  level;
      logic [2:0]  reason;
      logic [15:0] time_to_collision;
      logic        ttc_valid;
      logic [1:0]  frame_level;
      logic        frame_end;
   } ttc_rsp_type;

   typedef struct packed {
      logic [15:0] ttc_critical_limit;
      logic [15:0] ttc_warning_limit;
      logic [14:0] ego_lane_half_width;
      logic [14:0] warn_zone_half_width;
      logic [14:0] max_distance;
      logic [14:0] min_closing_speed;
      logic [14:0] imminent_distance;
   } ttc_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ttc_div_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_FINISH
   } ttc_state_type;

endpackage

// ===== src/ttc_collision_threat_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// Collision threat classifier
// Classifies one tracked object per beat as safe, warning or critical from
// its lateral offset, distance and time to collision; keeps a per-frame
// worst level.
//
//   Channel   Direction   Handshake             Beat
//   req_      in          req_valid/req_ready   ttc_req_type
//   rsp_      out         rsp_valid/rsp_ready   ttc_rsp_type
//   csr_      in          csr_valid/csr_ready   csr_index, csr_data
//
// An approaching object's time to collision comes from the serial divider,
// which produces one quotient bit per cycle over 15 + FRACTION_BITS bits;
// any other object skips the divider. One object is in work at a time; the
// result register lets the next object be accepted while a result waits on
// rsp_ready. Reset is synchronous and clears the sequencer, the result valid
// and the frame level, and loads the limit registers with their reset values.
// ----------------------------------------------------------------------------
`include "ttc_collision_threat_classifier_unit_macros.svh"

module ttc_collision_threat_classifier_unit #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ttc_pkg::ttc_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ttc_pkg::ttc_rsp_type rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data
);
   import ttc_pkg::*;

   localparam int          QW        = 15 + FRACTION_BITS;
   localparam logic [15:0] LAT_LIMIT = 16'((5 << FRACTION_BITS) >> 1);
   localparam logic [17:0] LANE_WARN = 18'(20 << FRACTION_BITS);

   ttc_cfg_type        cfg;
   ttc_div_status_type div_status;
   logic [QW-1:0]      quotient;
   logic [QW-1:0]      dividend;

   ttc_state_type state_ff, state_in;
   ttc_req_type   item_ff, item_in;
   ttc_rsp_type   rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    worst_ff, worst_in;

   logic          req_ready_c;
   logic          div_start;
   logic          finish_en;

   // object geometry
   logic [15:0]        lat;
   logic [14:0]        fwd_dist;
   logic               in_window;
   logic signed [16:0] vy_ext;
   logic signed [16:0] min_neg;
   logic               approaching;
   logic [15:0]        speed;
   logic               in_lane;
   logic               imminent;
   logic               in_zone;

   // classification
   logic [15:0] ttc_sat;
   logic        q_lt_crit;
   logic        q_lt_warn;
   logic [1:0]  level;
   logic [2:0]  reason;
   logic [15:0] ttc;
   logic        ttc_ok;
   logic [1:0]  frame_level;

   ttc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ttc_div #(
      .DIVIDEND_W (QW),
      .DIVISOR_W  (16)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (speed),
      .quotient (quotient),
      .status   (div_status)
   );

   always_comb begin
      lat = item_ff.lateral_position[15] ? 16'(~item_ff.lateral_position + 16'sd1)
                                         : item_ff.lateral_position;
      fwd_dist  = item_ff.distance[14:0];
      in_window = !item_ff.distance[15] && (fwd_dist != '0)
                  && (fwd_dist <= cfg.max_distance) && (lat <= LAT_LIMIT);
      vy_ext      = {item_ff.forward_velocity[15], item_ff.forward_velocity};
      min_neg     = 17'sd0 - $signed({2'b00, cfg.min_closing_speed});
      approaching = vy_ext < min_neg;
      speed       = 16'(~item_ff.forward_velocity + 16'sd1);
      in_lane     = lat < {1'b0, cfg.ego_lane_half_width};
      imminent    = fwd_dist < cfg.imminent_distance;
      in_zone     = (lat < {1'b0, cfg.warn_zone_half_width}) && approaching
                    && ({3'b000, fwd_dist} < LANE_WARN);
      dividend    = {fwd_dist, {FRACTION_BITS{1'b0}}};
   end

   always_comb begin
      ttc_sat   = (|quotient[QW-1:16]) ? TTC_MAX : quotient[15:0];
      q_lt_crit = quotient < {{(QW-16){1'b0}}, cfg.ttc_critical_limit};
      q_lt_warn = quotient < {{(QW-16){1'b0}}, cfg.ttc_warning_limit};
      level  = LVL_SAFE;
      reason = RSN_SAFE;
      ttc    = '0;
      ttc_ok = 1'b0;
      if (in_window) begin
         if (in_lane && approaching) begin
            ttc_ok = 1'b1;
            ttc    = ttc_sat;
            if (q_lt_crit) begin
               level  = LVL_CRITICAL;
               reason = RSN_FWD_CRITICAL;
            end else if (q_lt_warn) begin
               level  = LVL_WARNING;
               reason = RSN_FWD_WARNING;
            end
         end else if (in_lane && imminent) begin
            level  = LVL_CRITICAL;
            reason = RSN_IMMINENT;
         end else if (in_zone) begin
            ttc_ok = 1'b1;
            ttc    = ttc_sat;
            if (q_lt_warn) begin
               level  = LVL_WARNING;
               reason = RSN_LANE_WARNING;
            end
         end
      end
      frame_level = (level > worst_ff) ? level : worst_ff;
   end

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_START;
         end
         ST_START: begin
            state_in = approaching ? ST_DIV : ST_FINISH;
         end
         ST_DIV: begin
            if (div_status.done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_ready_c = 1'b0;
      div_start   = 1'b0;
      finish_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready_c = 1'b1;
         ST_START:  div_start   = approaching;
         ST_DIV:    ;
         ST_FINISH: finish_en   = !rsp_valid_ff || rsp_ready;
         default:   ;
      endcase
   end

   always_comb begin
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      worst_in     = worst_ff;
      if (req_valid && req_ready_c) item_in = req_payload;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (finish_en) begin
         rsp_valid_in             = 1'b1;
         rsp_in.object_id         = item_ff.target_id;
         rsp_in.level             = level;
         rsp_in.reason            = reason;
         rsp_in.time_to_collision = ttc;
         rsp_in.ttc_valid         = ttc_ok;
         rsp_in.frame_level       = frame_level;
         rsp_in.frame_end         = item_ff.last;
         // clear the frame after its last object
         worst_in = item_ff.last ? LVL_SAFE : frame_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         worst_ff     <= LVL_SAFE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         worst_ff     <= worst_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready   = req_ready_c;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `TTC_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `TTC_ASSERT_IMP(a_frame_not_below_level, clock, reset, rsp_valid, rsp_payload.frame_level >= rsp_payload.level)
   `TTC_ASSERT_IMP(a_ttc_zero_when_unused, clock, reset, rsp_valid && !rsp_payload.ttc_valid, rsp_payload.time_to_collision == 16'd0)
   `TTC_ASSERT_IMP(a_div_done_in_div_state, clock, reset, div_status.done, state_ff == ST_DIV)

endmodule

// ===== src/ttc_csr.sv =====
// ----------------------------------------------------------------------------
// Collision threat classifier register file
// Holds the seven limit registers, written through the csr channel.
// ----------------------------------------------------------------------------
module ttc_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output ttc_pkg::ttc_cfg_type cfg
);
   import ttc_pkg::*;

   ttc_cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TTC_CRITICAL_LIMIT:   cfg_in.ttc_critical_limit   = csr_data;
            CSR_TTC_WARNING_LIMIT:    cfg_in.ttc_warning_limit    = csr_data;
            CSR_EGO_LANE_HALF_WIDTH:  cfg_in.ego_lane_half_width  = csr_data[14:0];
            CSR_WARN_ZONE_HALF_WIDTH: cfg_in.warn_zone_half_width = csr_data[14:0];
            CSR_MAX_DISTANCE:         cfg_in.max_distance         = csr_data[14:0];
            CSR_MIN_CLOSING_SPEED:    cfg_in.min_closing_speed    = csr_data[14:0];
            CSR_IMMINENT_DISTANCE:    cfg_in.imminent_distance    = csr_data[14:0];
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ttc_critical_limit   <= RST_TTC_CRITICAL_LIMIT;
         cfg_ff.ttc_warning_limit    <= RST_TTC_WARNING_LIMIT;
         cfg_ff.ego_lane_half_width  <= RST_EGO_LANE_HALF_WIDTH;
         cfg_ff.warn_zone_half_width <= RST_WARN_ZONE_HALF_WIDTH;
         cfg_ff.max_distance         <= RST_MAX_DISTANCE;
         cfg_ff.min_closing_speed    <= RST_MIN_CLOSING_SPEED;
         cfg_ff.imminent_distance    <= RST_IMMINENT_DISTANCE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/ttc_div.sv =====
// ----------------------------------------------------------------------------
// Collision threat classifier divider
// Restoring radix-2 divider, one quotient bit per cycle, shared subtractor.
// ----------------------------------------------------------------------------
module ttc_div #(
   parameter int DIVIDEND_W = 23,
   parameter int DIVISOR_W  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DIVIDEND_W-1:0]       dividend,
   input  logic [DIVISOR_W-1:0]        divisor,
   output logic [DIVIDEND_W-1:0]       quotient,
   output ttc_pkg::ttc_div_status_type status
);
   import ttc_pkg::*;

   localparam int CW = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // shift in the next dividend bit and try one subtract
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DIVIDEND_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
